>>> rtl/core/pn1d_pkg.sv
// ----------------------------------------------------------------------------
// pn1d_pkg
// Lattice permutation and gradient decode shared by the 1-D gradient noise core.
// ----------------------------------------------------------------------------
package pn1d_pkg;

  typedef logic signed [4:0] grad_t;

  localparam logic [7:0] PERM_TABLE [0:255] = '{
    8'd63, 8'd9, 8'd212, 8'd205, 8'd31, 8'd128, 8'd72, 8'd59, 8'd137, 8'd203, 8'd195, 8'd170,
    8'd181, 8'd115, 8'd165, 8'd40, 8'd116, 8'd139, 8'd175, 8'd225, 8'd132, 8'd99, 8'd222, 8'd2,
    8'd41, 8'd15, 8'd197, 8'd93, 8'd169, 8'd90, 8'd228, 8'd43, 8'd221, 8'd38, 8'd206, 8'd204,
    8'd73, 8'd17, 8'd97, 8'd10, 8'd96, 8'd47, 8'd32, 8'd138, 8'd136, 8'd30, 8'd219, 8'd78,
    8'd224, 8'd13, 8'd193, 8'd88, 8'd134, 8'd211, 8'd7, 8'd112, 8'd176, 8'd19, 8'd106, 8'd83,
    8'd75, 8'd217, 8'd85, 8'd0, 8'd98, 8'd140, 8'd229, 8'd80, 8'd118, 8'd151, 8'd117, 8'd251,
    8'd103, 8'd242, 8'd81, 8'd238, 8'd172, 8'd82, 8'd110, 8'd4, 8'd227, 8'd77, 8'd243, 8'd46,
    8'd12, 8'd189, 8'd34, 8'd188, 8'd200, 8'd161, 8'd68, 8'd76, 8'd171, 8'd194, 8'd57, 8'd48,
    8'd247, 8'd233, 8'd51, 8'd105, 8'd5, 8'd23, 8'd42, 8'd50, 8'd216, 8'd45, 8'd239, 8'd148,
    8'd249, 8'd84, 8'd70, 8'd125, 8'd108, 8'd241, 8'd62, 8'd66, 8'd64, 8'd240, 8'd173, 8'd185,
    8'd250, 8'd49, 8'd6, 8'd37, 8'd26, 8'd21, 8'd244, 8'd60, 8'd223, 8'd255, 8'd16, 8'd145,
    8'd27, 8'd109, 8'd58, 8'd102, 8'd142, 8'd253, 8'd120, 8'd149, 8'd160, 8'd124, 8'd156, 8'd79,
    8'd186, 8'd135, 8'd127, 8'd14, 8'd121, 8'd22, 8'd65, 8'd54, 8'd153, 8'd91, 8'd213, 8'd174,
    8'd24, 8'd252, 8'd131, 8'd192, 8'd190, 8'd202, 8'd208, 8'd35, 8'd94, 8'd231, 8'd56, 8'd95,
    8'd183, 8'd163, 8'd111, 8'd147, 8'd25, 8'd67, 8'd36, 8'd92, 8'd236, 8'd71, 8'd166, 8'd1,
    8'd187, 8'd100, 8'd130, 8'd143, 8'd237, 8'd178, 8'd158, 8'd104, 8'd184, 8'd159, 8'd177, 8'd52,
    8'd214, 8'd230, 8'd119, 8'd87, 8'd114, 8'd201, 8'd179, 8'd198, 8'd3, 8'd248, 8'd182, 8'd39,
    8'd11, 8'd152, 8'd196, 8'd113, 8'd20, 8'd232, 8'd69, 8'd141, 8'd207, 8'd234, 8'd53, 8'd86,
    8'd180, 8'd226, 8'd74, 8'd150, 8'd218, 8'd29, 8'd133, 8'd8, 8'd44, 8'd123, 8'd28, 8'd146,
    8'd89, 8'd101, 8'd154, 8'd220, 8'd126, 8'd155, 8'd122, 8'd210, 8'd168, 8'd254, 8'd162, 8'd129,
    8'd33, 8'd18, 8'd209, 8'd61, 8'd191, 8'd199, 8'd157, 8'd245, 8'd55, 8'd164, 8'd167, 8'd215,
    8'd246, 8'd144, 8'd107, 8'd235
  };

  // gradient in eighths: h-8 for h below 8, h-7 otherwise
  function automatic grad_t slope(input logic [7:0] entry);
    logic signed [4:0] h;
    begin
      h = $signed({1'b0, entry[3:0]});
      if (entry[3]) begin
        slope = h - 5'sd7;
      end else begin
        slope = h - 5'sd8;
      end
    end
  endfunction

endpackage

>>> rtl/core/perlin_noise_1d_core.sv
// ----------------------------------------------------------------------------
// perlin_noise_1d_core
// Pipelined 1-D gradient noise: signed fixed-point position in, saturated
// fixed-point noise out, one transfer per clock while out_ is not stalled.
// ----------------------------------------------------------------------------
//  channel | direction | payload                      | handshake
//  in_     | input     | in_position  (32b signed)    | in_valid / in_stall
//  out_    | output    | out_noise    (16b signed)    | out_valid / out_stall
//
//  One item enters per cycle while in_stall is low. It passes five work stages
//  plus the output register; the fade and blend need four chained multiplies.
//  Reset clears the stage valid bits only; the data path is not reset.
//  A stall on out_ fills empty stages first and reaches in_stall only when
//  every stage holds an item.
// ----------------------------------------------------------------------------
module perlin_noise_1d_core #(
  parameter int FRAC_BITS     = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_noise
);

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 5;
  localparam int DW  = F + 6;
  localparam int UW  = F + 1;
  localparam int PW  = DW + UW;
  localparam int LW  = F + 8;
  localparam int SQW = 2 * F;
  localparam int QW  = F + 4;
  localparam int QFW = 2 * F + 4;
  localparam int SH  = F + 2 - OUT_FRAC_BITS;
  localparam int NEG = (SH < 0) ? -SH : 0;
  localparam int RW  = LW + NEG;

  localparam logic signed [AW-1:0] ONE_S  = AW'(2 ** F);
  localparam logic [QFW-1:0]       TEN_SQ = QFW'(10) << (2 * F);
  localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
  localparam logic signed [RW-1:0] SAT_MIN = -RW'(32768);

  // stage enables and valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !out_valid_r || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) out_valid_r <= v5_r;
    end
  end

  // stage 1: lattice lookup
  logic [7:0]          lattice_idx;
  logic [F-1:0]        t1_r,  t1_nxt;
  pn1d_pkg::grad_t     ga1_r, ga1_nxt;
  pn1d_pkg::grad_t     gb1_r, gb1_nxt;

  always_comb begin
    lattice_idx = in_position[F+7:F];
    t1_nxt      = in_position[F-1:0];
    ga1_nxt     = pn1d_pkg::slope(pn1d_pkg::PERM_TABLE[lattice_idx]);
    gb1_nxt     = pn1d_pkg::slope(pn1d_pkg::PERM_TABLE[lattice_idx + 8'd1]);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1_r  <= t1_nxt;
      ga1_r <= ga1_nxt;
      gb1_r <= gb1_nxt;
    end
  end

  // stage 2: t squared and the two gradient products
  logic [SQW-1:0]        sq2_r, sq2_nxt;
  logic [F-1:0]          t2_r;
  logic signed [AW-1:0]  a2_r, a2_nxt;
  logic signed [AW-1:0]  b2_r, b2_nxt;
  logic signed [AW-1:0]  ts1;

  always_comb begin
    ts1     = AW'($signed({1'b0, t1_r}));
    sq2_nxt = SQW'(t1_r) * SQW'(t1_r);
    a2_nxt  = AW'(ga1_r) * ts1;
    b2_nxt  = AW'(gb1_r) * (ts1 - ONE_S);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sq2_r <= sq2_nxt;
      t2_r  <= t1_r;
      a2_r  <= a2_nxt;
      b2_r  <= b2_nxt;
    end
  end

  // stage 3: t cubed, fade polynomial factor, product difference
  logic [SQW-1:0]        prod3;
  logic [QFW-1:0]        sq_w, tf_w, qfull;
  logic [F-1:0]          t3_r, t3_nxt;
  logic [QW-1:0]         q3_r, q3_nxt;
  logic signed [DW-1:0]  d3_r, d3_nxt;
  logic signed [AW-1:0]  a3_r;

  always_comb begin
    prod3  = SQW'(sq2_r[SQW-1:F]) * SQW'(t2_r);
    t3_nxt = prod3[SQW-1:F];
    sq_w   = QFW'(sq2_r);
    tf_w   = QFW'(t2_r) << F;
    qfull  = (sq_w << 2) + (sq_w << 1) + TEN_SQ - ((tf_w << 4) - tf_w);
    q3_nxt = qfull[QFW-1:F];
    d3_nxt = DW'(b2_r) - DW'(a2_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      t3_r <= t3_nxt;
      q3_r <= q3_nxt;
      d3_r <= d3_nxt;
      a3_r <= a2_r;
    end
  end

  // stage 4: fade weight
  logic [QFW-1:0]        prod4;
  logic [UW-1:0]         u4_r, u4_nxt;
  logic signed [DW-1:0]  d4_r;
  logic signed [AW-1:0]  a4_r;

  always_comb begin
    prod4  = QFW'(t3_r) * QFW'(q3_r);
    u4_nxt = prod4[F+UW-1:F];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      u4_r <= u4_nxt;
      d4_r <= d3_r;
      a4_r <= a3_r;
    end
  end

  // stage 5: weighted difference
  logic signed [PW-1:0]  p5_r, p5_nxt;
  logic signed [AW-1:0]  a5_r;

  always_comb begin
    p5_nxt = PW'(d4_r) * PW'($signed({1'b0, u4_r}));
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      p5_r <= p5_nxt;
      a5_r <= a4_r;
    end
  end

  // stage 6: blend, rescale, saturate
  logic signed [LW-1:0]  lv;
  logic signed [RW-1:0]  lv_ext;
  logic signed [RW-1:0]  r;
  logic signed [15:0]    noise_r, noise_nxt;

  assign lv     = LW'(a5_r) + LW'(p5_r >>> F);
  assign lv_ext = RW'(lv);

  generate
    if (SH > 0) begin : g_narrow
      localparam logic signed [RW-1:0] RND = RW'(2 ** (SH - 1));
      assign r = (lv_ext + RND) >>> SH;
    end else begin : g_widen
      assign r = lv_ext <<< NEG;
    end
  endgenerate

  always_comb begin
    if (r > SAT_MAX) begin
      noise_nxt = 16'sh7fff;
    end else if (r < SAT_MIN) begin
      noise_nxt = -16'sh8000;
    end else begin
      noise_nxt = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      noise_r <= noise_nxt;
    end
  end

  assign out_noise = noise_r;

endmodule

>>> rtl/core/pn1d_checker.sv
// ----------------------------------------------------------------------------
// pn1d_checker
// Port-level checks for the 1-D gradient noise core, bound to its top level.
// ----------------------------------------------------------------------------
module pn1d_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_position,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_noise
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise))
    else $error("stalled result changed");

  a_no_false_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("in_stall without downstream stall");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("transfer did not reach output in six cycles");

endmodule

bind perlin_noise_1d_core pn1d_checker u_pn1d_checker (.*);

>>> tb/perlin_noise_1d_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_1d_core_tb
// Drives sample positions into the 1-D gradient noise core under random
// sender gaps and receiver stalls. Each accepted position is turned into its
// expected noise value by a fixed-point model of the lattice lookup, the
// gradient products, the quintic fade blend and the saturating output scale.
// Results are matched in order against those values.
// ----------------------------------------------------------------------------
module perlin_noise_1d_core_tb;

  localparam int FRAC_BITS      = 16;
  localparam int OUT_FRAC_BITS  = 15;
  localparam int ROUND_SHIFT    = FRAC_BITS + 2 - OUT_FRAC_BITS;
  localparam int LATENCY        = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] position;
    logic signed [15:0] noise;
  } noise_sample_t;

  class noise_tracker;
    noise_sample_t expected_noise[$];
    int errors = 0;

    function longint gradient_eighths(input logic [7:0] entry);
      longint h;
      h = longint'(entry[3:0]);
      return (h < 8) ? h - 8 : h - 7;
    endfunction

    function logic signed [15:0] noise_at(input logic [31:0] position);
      longint unit, t, t2, t3, q, u, a, b, lv, r;
      logic [7:0] lattice_idx, next_idx;
      unit = longint'(1) << FRAC_BITS;
      t = longint'(position[FRAC_BITS-1:0]);
      lattice_idx = position[FRAC_BITS +: 8];
      next_idx = lattice_idx + 8'd1;
      t2 = (t * t) >>> FRAC_BITS;
      t3 = (t2 * t) >>> FRAC_BITS;
      q = (6 * t * t + 10 * unit * unit - 15 * t * unit) >>> FRAC_BITS;
      u = (t3 * q) >>> FRAC_BITS;
      a = gradient_eighths(pn1d_pkg::PERM_TABLE[lattice_idx]) * t;
      b = gradient_eighths(pn1d_pkg::PERM_TABLE[next_idx]) * (t - unit);
      lv = a + (((b - a) * u) >>> FRAC_BITS);
      if (ROUND_SHIFT > 0) begin
        r = (lv + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      end else begin
        r = lv * (longint'(1) << (-ROUND_SHIFT));
      end
      if (r > 32767) begin
        r = 32767;
      end
      if (r < -32768) begin
        r = -32768;
      end
      return r[15:0];
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function void note_position(input logic signed [31:0] position);
      noise_sample_t sample;
      sample.position = position;
      sample.noise = noise_at(position);
      expected_noise.push_back(sample);
    endfunction

    task check_noise(input logic signed [15:0] got);
      noise_sample_t sample;
      if (expected_noise.size() == 0) begin
        report($sformatf("noise %0d with no position outstanding", got));
      end else begin
        sample = expected_noise.pop_front();
        if (got !== sample.noise) begin
          report($sformatf("position %h: noise %0d, predicted %0d",
                           sample.position, got, sample.noise));
        end
      end
    endtask

    function int pending();
      return expected_noise.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_noise;

  noise_tracker tracker = new();
  int in_gap_max = 16;
  int out_stall_max = 16;
  bit hold_outputs = 1'b0;
  int idle_cycles = 0;

  perlin_noise_1d_core #(
    .FRAC_BITS    (FRAC_BITS),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_noise  (out_noise)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_position(input logic signed [31:0] position);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position <= position;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_position(position);
  endtask

  task automatic send_random(input int count);
    logic signed [31:0] position;
    int kind;
    for (int i = 0; i < count; i++) begin
      position = $urandom();
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        case ($urandom_range(0, 4))
          0: position[FRAC_BITS-1:0] = '0;
          1: position[FRAC_BITS-1:0] = {{(FRAC_BITS-1){1'b0}}, 1'b1};
          2: position[FRAC_BITS-1:0] = {1'b0, {(FRAC_BITS-1){1'b1}}};
          3: position[FRAC_BITS-1:0] = {1'b1, {(FRAC_BITS-1){1'b0}}};
          default: position[FRAC_BITS-1:0] = '1;
        endcase
      end else if (kind < 4) begin
        position[FRAC_BITS +: 8] = (kind == 2) ? 8'd255 : 8'd41 + 8'($urandom_range(0, 1));
      end
      send_position(position);
    end
  endtask

  task automatic drain_results();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_outputs) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_outputs = 1'b0;
      end else begin
        n = $urandom_range(0, out_stall_max);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_noise(out_noise);
    end
  end

  initial begin
    logic signed [31:0] corners[$];
    corners = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF, 32'h00FF_0000,
      32'h00FF_0001, 32'h00FF_8000, 32'h00FF_FFFF, 32'hFFFF_8000,
      32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0029_8000,
      32'h0029_7000, 32'h0029_9000, 32'h002A_8000, 32'h8012_4000
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corners[i]) begin
      send_position(corners[i]);
    end
    send_random(300);
    in_gap_max = 0;
    out_stall_max = 0;
    send_random(150);
    in_valid <= 1'b0;
    drain_results();

    // fill the pipeline against a long output hold
    out_stall_max = 4;
    hold_outputs = 1'b1;
    send_random(200);
    in_gap_max = 16;
    out_stall_max = 0;
    send_random(200);
    in_gap_max = 0;
    out_stall_max = 16;
    send_random(200);
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
